// File: sv/q15l_pkg.sv
// Shared constants, types and the log10 ROM for the Q15 log10 unit.
package q15l_pkg;

    localparam int MANT_W  = 15;
    localparam int EXP_W   = 16;
    localparam int RES_W   = 16;
    localparam int SHIFT_W = 4;
    localparam int IDX_W   = 8;
    localparam int ROM_W   = 16;
    localparam int TERM_W  = 13;
    localparam int COEF_W  = 11;

    localparam logic [MANT_W-1:0] NORM_LIMIT = 15'h3fff;
    localparam logic [15:0]       ROUND_HALF = 16'h0040;
    localparam logic [8:0]        ROM_OFFSET = 9'd128;
    localparam logic [COEF_W-1:0] EXP_COEF   = 11'd1228;
    localparam logic [IDX_W-1:0]  ROM_LAST   = 8'd128;

    typedef struct packed {
        logic busy;
        logic done;
    } norm_status_t;

    function automatic logic signed [ROM_W-1:0] log_rom(input logic [IDX_W-1:0] idx);
        logic signed [ROM_W-1:0] v;
        case (idx)
            8'd0:   v = -16'sd9864; 8'd1:   v = -16'sd9753; 8'd2:   v = -16'sd9643;
            8'd3:   v = -16'sd9534; 8'd4:   v = -16'sd9426; 8'd5:   v = -16'sd9318;
            8'd6:   v = -16'sd9212; 8'd7:   v = -16'sd9106; 8'd8:   v = -16'sd9001;
            8'd9:   v = -16'sd8897; 8'd10:  v = -16'sd8793; 8'd11:  v = -16'sd8690;
            8'd12:  v = -16'sd8588; 8'd13:  v = -16'sd8487; 8'd14:  v = -16'sd8387;
            8'd15:  v = -16'sd8287; 8'd16:  v = -16'sd8187; 8'd17:  v = -16'sd8089;
            8'd18:  v = -16'sd7991; 8'd19:  v = -16'sd7894; 8'd20:  v = -16'sd7798;
            8'd21:  v = -16'sd7702; 8'd22:  v = -16'sd7607; 8'd23:  v = -16'sd7512;
            8'd24:  v = -16'sd7418; 8'd25:  v = -16'sd7325; 8'd26:  v = -16'sd7232;
            8'd27:  v = -16'sd7140; 8'd28:  v = -16'sd7048; 8'd29:  v = -16'sd6957;
            8'd30:  v = -16'sd6867; 8'd31:  v = -16'sd6777; 8'd32:  v = -16'sd6688;
            8'd33:  v = -16'sd6599; 8'd34:  v = -16'sd6511; 8'd35:  v = -16'sd6424;
            8'd36:  v = -16'sd6337; 8'd37:  v = -16'sd6250; 8'd38:  v = -16'sd6164;
            8'd39:  v = -16'sd6079; 8'd40:  v = -16'sd5994; 8'd41:  v = -16'sd5909;
            8'd42:  v = -16'sd5825; 8'd43:  v = -16'sd5742; 8'd44:  v = -16'sd5659;
            8'd45:  v = -16'sd5576; 8'd46:  v = -16'sd5494; 8'd47:  v = -16'sd5413;
            8'd48:  v = -16'sd5332; 8'd49:  v = -16'sd5251; 8'd50:  v = -16'sd5171;
            8'd51:  v = -16'sd5091; 8'd52:  v = -16'sd5012; 8'd53:  v = -16'sd4933;
            8'd54:  v = -16'sd4855; 8'd55:  v = -16'sd4777; 8'd56:  v = -16'sd4699;
            8'd57:  v = -16'sd4622; 8'd58:  v = -16'sd4545; 8'd59:  v = -16'sd4469;
            8'd60:  v = -16'sd4393; 8'd61:  v = -16'sd4318; 8'd62:  v = -16'sd4243;
            8'd63:  v = -16'sd4168; 8'd64:  v = -16'sd4093; 8'd65:  v = -16'sd4020;
            8'd66:  v = -16'sd3946; 8'd67:  v = -16'sd3873; 8'd68:  v = -16'sd3800;
            8'd69:  v = -16'sd3728; 8'd70:  v = -16'sd3656; 8'd71:  v = -16'sd3584;
            8'd72:  v = -16'sd3513; 8'd73:  v = -16'sd3442; 8'd74:  v = -16'sd3371;
            8'd75:  v = -16'sd3301; 8'd76:  v = -16'sd3231; 8'd77:  v = -16'sd3161;
            8'd78:  v = -16'sd3092; 8'd79:  v = -16'sd3023; 8'd80:  v = -16'sd2954;
            8'd81:  v = -16'sd2886; 8'd82:  v = -16'sd2818; 8'd83:  v = -16'sd2751;
            8'd84:  v = -16'sd2683; 8'd85:  v = -16'sd2616; 8'd86:  v = -16'sd2550;
            8'd87:  v = -16'sd2483; 8'd88:  v = -16'sd2417; 8'd89:  v = -16'sd2352;
            8'd90:  v = -16'sd2286; 8'd91:  v = -16'sd2221; 8'd92:  v = -16'sd2156;
            8'd93:  v = -16'sd2092; 8'd94:  v = -16'sd2027; 8'd95:  v = -16'sd1963;
            8'd96:  v = -16'sd1900; 8'd97:  v = -16'sd1836; 8'd98:  v = -16'sd1773;
            8'd99:  v = -16'sd1710; 8'd100: v = -16'sd1648; 8'd101: v = -16'sd1586;
            8'd102: v = -16'sd1524; 8'd103: v = -16'sd1462; 8'd104: v = -16'sd1400;
            8'd105: v = -16'sd1339; 8'd106: v = -16'sd1278; 8'd107: v = -16'sd1218;
            8'd108: v = -16'sd1157; 8'd109: v = -16'sd1097; 8'd110: v = -16'sd1037;
            8'd111: v = -16'sd977;  8'd112: v = -16'sd918;  8'd113: v = -16'sd859;
            8'd114: v = -16'sd800;  8'd115: v = -16'sd741;  8'd116: v = -16'sd683;
            8'd117: v = -16'sd625;  8'd118: v = -16'sd567;  8'd119: v = -16'sd509;
            8'd120: v = -16'sd451;  8'd121: v = -16'sd394;  8'd122: v = -16'sd337;
            8'd123: v = -16'sd280;  8'd124: v = -16'sd224;  8'd125: v = -16'sd167;
            8'd126: v = -16'sd111;  8'd127: v = -16'sd55;   8'd128: v = 16'sd10;
            default: v = 16'sd10;
        endcase
        return v;
    endfunction

endpackage

// File: sv/q15l_norm.sv
// Iterative normaliser: shifts the mantissa left one bit a cycle and counts the shifts.
module q15l_norm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [q15l_pkg::MANT_W-1:0]     mant,
    output logic [q15l_pkg::MANT_W-1:0]     norm,
    output logic [q15l_pkg::SHIFT_W-1:0]    shifts,
    output q15l_pkg::norm_status_t          status
);
    import q15l_pkg::*;

    logic                busy_reg;
    logic [MANT_W-1:0]   norm_reg;
    logic [SHIFT_W-1:0]  cnt_reg;
    logic                finished;

    // normalised once the value exceeds the limit, i.e. its top bit is set
    assign finished = busy_reg && (norm_reg > NORM_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (finished) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            norm_reg <= mant;
            cnt_reg  <= '0;
        end else if (busy_reg && !finished) begin
            norm_reg <= {norm_reg[MANT_W-2:0], 1'b0};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign norm        = norm_reg;
    assign shifts      = cnt_reg;
    assign status.busy = busy_reg;
    assign status.done = finished;

    a_done_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> norm_reg[MANT_W-1])
        else $error("normaliser finished without top bit set");
    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> (cnt_reg <= SHIFT_W'(MANT_W - 1)))
        else $error("normaliser shifted too far");
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.done && !start) |=> !busy_reg)
        else $error("normaliser stayed busy after finishing");

endmodule

// File: sv/q15l_log10_unit_top.sv
// Top level of the Q15 log10 unit: sequencer, ROM lookup, exponent term and output register.
//
// Usage:
//   Input words (s_mantissa Q15, s_exponent signed) are taken on s_valid && s_ready.
//   Each word gives exactly one result word (m_log_value Q12, m_zero_input) on m_valid.
//   One item is worked at a time; s_ready is high only while the sequencer is idle.
//   A nonzero mantissa with s leading shifts (s = 0..14, one normaliser step per
//   cycle) passes through the NORM, LOOK, MUL and DONE steps before its result
//   shows, and the next word can be taken only once the sequencer is idle again.
//   A zero mantissa skips the normaliser and goes straight to DONE: flag set,
//   value 0, and the next word can be taken once DONE has passed the result on.
//   The exponent term uses one 16x11 multiply, registered before the final subtract.
//   The result sits in an output register, so a new word may be accepted while the
//   previous result waits; if the receiver stalls, the finished item holds in the
//   last sequencer step until the output register frees.
//   Reset (aresetn low, synchronous) empties the sequencer and the output register.
module q15_log10_table_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [q15l_pkg::MANT_W-1:0]         s_mantissa,
    input  logic signed [q15l_pkg::EXP_W-1:0]   s_exponent,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [q15l_pkg::RES_W-1:0]   m_log_value,
    output logic                                m_zero_input
);
    import q15l_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [EXP_W-1:0]           exp_reg;
    logic [EXP_W-1:0]           e_reg;
    logic signed [TERM_W-1:0]   term_reg;
    logic [RES_W-1:0]           prod_reg;
    logic                       zero_reg;
    logic                       m_valid_reg;
    logic signed [RES_W-1:0]    log_reg;
    logic                       flag_reg;

    logic                       in_fire;
    logic                       norm_start;
    logic [MANT_W-1:0]          norm_val;
    logic [SHIFT_W-1:0]         norm_shifts;
    norm_status_t               norm_stat;
    logic [15:0]                round_sum;
    logic [8:0]                 idx_wide;
    logic [IDX_W-1:0]           idx;
    logic signed [ROM_W-1:0]    rom_val;
    logic [EXP_W+COEF_W-1:0]    prod_full;
    logic                       out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign norm_start = in_fire && (s_mantissa != '0);
    assign out_free   = !m_valid_reg || m_ready;

    q15l_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .mant    (s_mantissa),
        .norm    (norm_val),
        .shifts  (norm_shifts),
        .status  (norm_stat)
    );

    // round to the table step, then drop the 0x4000 base
    assign round_sum = {1'b0, norm_val} + ROUND_HALF;
    assign idx_wide  = round_sum[15:7] - ROM_OFFSET;
    assign idx       = (idx_wide > {1'b0, ROM_LAST}) ? ROM_LAST : idx_wide[IDX_W-1:0];
    assign rom_val   = log_rom(idx);
    assign prod_full = e_reg * EXP_COEF;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = (s_mantissa == '0) ? ST_DONE : ST_NORM;
            end
            ST_NORM: begin
                if (norm_stat.done) state_next = ST_LOOK;
            end
            ST_LOOK: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            exp_reg  <= s_exponent;
            zero_reg <= (s_mantissa == '0);
        end
        if (state_reg == ST_LOOK) begin
            e_reg    <= exp_reg + EXP_W'(norm_shifts);
            term_reg <= TERM_W'(rom_val >>> 3);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_full[RES_W-1:0];
        end
        if (state_reg == ST_DONE && out_free) begin
            flag_reg <= zero_reg;
            log_reg  <= zero_reg ? '0 : RES_W'(RES_W'(term_reg) - $signed(prod_reg));
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_log_value  = log_reg;
    assign m_zero_input = flag_reg;

    a_zero_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_mantissa == '0) |=> (state_reg == ST_DONE && zero_reg))
        else $error("zero mantissa did not bypass the normaliser");
    a_nonzero_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_mantissa != '0) |=> (state_reg == ST_NORM && norm_stat.busy))
        else $error("nonzero mantissa did not start the normaliser");
    a_flag_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_input) |-> (m_log_value == '0))
        else $error("zero flag with nonzero result");
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> (idx_wide <= {1'b0, ROM_LAST}))
        else $error("ROM index out of range");

endmodule
